>>> rtl/core/tdpc_pkg.sv
// Shared types, constants and the divisor inverse table for the trial-division
// prime counter. No dependencies.

package tdpc_pkg;

    localparam int FIELD_BITS     = 16;  // width of value and tested_value
    localparam int COUNT_BITS     = 32;  // width of prime_count
    localparam int VALUE_BITS_DEF = 16;
    localparam int FIRST_DIV      = 3;

    // Largest divisor tried is 255 (255*255 < 2**16 <= 257*257), so the
    // divisor fits in 8 bits; the stepping register needs one more for 257.
    localparam int DVS_BITS  = 8;
    localparam int DIV_BITS  = DVS_BITS + 1;
    localparam int SQ_BITS   = 2 * DIV_BITS - 1;
    localparam int IDX_BITS  = DVS_BITS - 1;
    localparam int INV_DEPTH = 1 << IDX_BITS;
    localparam int PROD_BITS = FIELD_BITS + DVS_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Divisor issued to the divisibility unit
    typedef struct packed {
        logic                valid;
        logic [DVS_BITS-1:0] divisor;
    } issue_t;

    // Verdict returned by the divisibility unit
    typedef struct packed {
        logic valid;
        logic hit;   // divisor divides the number
    } res_t;

    typedef logic [FIELD_BITS-1:0] inv_tab_t [INV_DEPTH];

    // Inverse of each odd d modulo 2**FIELD_BITS, indexed by d >> 1.
    // Newton steps: x = d is exact to 3 bits, each step doubles that.
    function automatic inv_tab_t build_inv_tab();
        inv_tab_t              t;
        logic [FIELD_BITS-1:0] d;
        logic [FIELD_BITS-1:0] x;
        for (int i = 0; i < INV_DEPTH; i++)
        begin
            d = FIELD_BITS'(2 * i + 1);
            x = d;
            for (int k = 0; k < 4; k++)
            begin
                x = FIELD_BITS'(x * FIELD_BITS'(FIELD_BITS'(2) - FIELD_BITS'(d * x)));
            end
            t[i] = x;
        end
        return t;
    endfunction

    localparam inv_tab_t INV_TAB = build_inv_tab();

endpackage

>>> rtl/core/tdpc_div_unit.sv
// Pipelined divisibility check: n * inv(d) mod 2**16 gives q, then q * d == n
// holds exactly when d divides n. Two register stages. Uses tdpc_pkg.

module tdpc_div_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             flush,
    input  tdpc_pkg::issue_t                 issue,
    input  logic [tdpc_pkg::FIELD_BITS-1:0]  n,
    output tdpc_pkg::res_t                   res,
    output logic                             busy
);

    logic                            v1_reg;
    logic                            v1_next;
    logic [tdpc_pkg::FIELD_BITS-1:0] q_reg;
    logic [tdpc_pkg::FIELD_BITS-1:0] q_next;
    logic [tdpc_pkg::DVS_BITS-1:0]   d_reg;
    logic                            v2_reg;
    logic                            v2_next;
    logic                            hit_reg;
    logic                            hit_next;
    logic [tdpc_pkg::PROD_BITS-1:0]  back_prod;

    always_comb
    begin
        v1_next  = issue.valid && !flush;
        q_next   = tdpc_pkg::FIELD_BITS'(n *
                   tdpc_pkg::INV_TAB[issue.divisor[tdpc_pkg::DVS_BITS-1:1]]);
        back_prod = tdpc_pkg::PROD_BITS'(q_reg) * tdpc_pkg::PROD_BITS'(d_reg);
        v2_next  = v1_reg && !flush;
        hit_next = (back_prod == tdpc_pkg::PROD_BITS'(n));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        d_reg   <= issue.divisor;
        hit_reg <= hit_next;
    end

    assign res.valid = v2_reg;
    assign res.hit   = hit_reg;
    assign busy      = v1_reg || v2_reg;

endmodule

>>> rtl/core/trial_division_prime_counter.sv
// Top level of the trial-division prime counter: sequencer, divisor stepping,
// output register and saturating prime count. Uses tdpc_pkg, tdpc_div_unit.

// Each item carries a number; the block masks it to VALUE_BITS bits, tests it
// by trial division with odd divisors 3, 5, 7 ... while d*d <= n, and returns
// one result: the verdict, the number and the running count of primes
// (saturating at all ones). Values 0, 1, 2 and even numbers go straight to
// the done state without a divisor. An odd number issues one divisor per
// cycle into a two-stage multiply-and-compare divisibility unit; a 16-bit
// prime needs 127 divisors. A composite stops at its first factor. in_ready
// is low while a number is under test; a finished result sits in the output
// register and the next item may be accepted while it waits.

module trial_division_prime_counter
#(
    parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tdpc_pkg::FIELD_BITS-1:0]  value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             is_prime,
    output logic [tdpc_pkg::FIELD_BITS-1:0]  tested_value,
    output logic [tdpc_pkg::COUNT_BITS-1:0]  prime_count
);

    localparam int FB = tdpc_pkg::FIELD_BITS;
    localparam int CB = tdpc_pkg::COUNT_BITS;
    localparam int DB = tdpc_pkg::DIV_BITS;
    localparam int SB = tdpc_pkg::SQ_BITS;
    localparam int NB = (VALUE_BITS < FB) ? VALUE_BITS : FB;
    localparam logic [FB-1:0] VMASK = FB'((64'd1 << NB) - 64'd1);

    tdpc_pkg::state_t state_reg;
    tdpc_pkg::state_t state_next;

    logic [FB-1:0] n_reg;
    logic [FB-1:0] n_next;
    logic [DB-1:0] d_reg;
    logic [DB-1:0] d_next;
    logic [SB-1:0] sq_reg;
    logic [SB-1:0] sq_next;
    logic          prime_reg;
    logic          prime_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_prime_reg;
    logic          out_prime_next;
    logic [FB-1:0] out_value_reg;
    logic [FB-1:0] out_value_next;
    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;

    logic [FB-1:0]    n_in;
    logic             flush;
    logic             busy;
    tdpc_pkg::issue_t issue;
    tdpc_pkg::res_t   res;

    tdpc_div_unit u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flush (flush),
        .issue (issue),
        .n     (n_reg),
        .res   (res),
        .busy  (busy)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        out_value_next = out_value_reg;
        count_next     = count_reg;
        issue.valid    = 1'b0;
        issue.divisor  = d_reg[tdpc_pkg::DVS_BITS-1:0];
        flush          = 1'b0;
        in_ready       = 1'b0;
        n_in           = value & VMASK;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tdpc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                flush    = 1'b1;
                if (in_valid)
                begin
                    n_next  = n_in;
                    d_next  = DB'(tdpc_pkg::FIRST_DIV);
                    sq_next = SB'(tdpc_pkg::FIRST_DIV * tdpc_pkg::FIRST_DIV);
                    if (n_in == FB'(2))
                    begin
                        prime_next = 1'b1;
                        state_next = tdpc_pkg::ST_DONE;
                    end
                    else if (n_in <= FB'(1) || !n_in[0])
                    begin
                        prime_next = 1'b0;
                        state_next = tdpc_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tdpc_pkg::ST_CHECK;
                    end
                end
            end
            tdpc_pkg::ST_CHECK:
            begin
                if (res.valid && res.hit)
                begin
                    prime_next = 1'b0;
                    state_next = tdpc_pkg::ST_DONE;
                end
                else if (sq_reg <= SB'(n_reg))
                begin
                    issue.valid = 1'b1;
                    d_next      = d_reg + DB'(2);
                    // (d+2)^2 = d^2 + 4d + 4
                    sq_next     = sq_reg + SB'({d_reg, 2'b00}) + SB'(4);
                end
                else
                begin
                    state_next = tdpc_pkg::ST_DRAIN;
                end
            end
            tdpc_pkg::ST_DRAIN:
            begin
                if (res.valid && res.hit)
                begin
                    prime_next = 1'b0;
                    state_next = tdpc_pkg::ST_DONE;
                end
                else if (!busy)
                begin
                    prime_next = 1'b1;
                    state_next = tdpc_pkg::ST_DONE;
                end
            end
            tdpc_pkg::ST_DONE:
            begin
                flush = 1'b1;
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = prime_reg;
                    out_value_next = n_reg;
                    if (prime_reg && (count_reg != {CB{1'b1}}))
                    begin
                        count_next = count_reg + CB'(1);
                    end
                    state_next = tdpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        prime_reg     <= prime_next;
        out_prime_reg <= out_prime_next;
        out_value_reg <= out_value_next;
    end

    assign out_valid    = out_valid_reg;
    assign is_prime     = out_prime_reg;
    assign tested_value = out_value_reg;
    assign prime_count  = count_reg;

endmodule

>>> bench/trial_division_prime_counter_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for trial_division_prime_counter: random and directed numbers,
// verdicts and running prime counts checked against a trial-division scoreboard.
// Depends on tdpc_pkg and the trial_division_prime_counter RTL.

typedef struct packed {
    logic                               is_prime;
    logic [tdpc_pkg::FIELD_BITS-1:0]    tested;
    logic [tdpc_pkg::COUNT_BITS-1:0]    count;
} verdict_t;

class prime_scoreboard;
    verdict_t                           verdicts[$];
    logic [tdpc_pkg::COUNT_BITS-1:0]    primes_seen;
    int                                 mismatches;
    int                                 numbers_noted;
    int                                 verdicts_checked;

    function new();
        primes_seen      = '0;
        mismatches       = 0;
        numbers_noted    = 0;
        verdicts_checked = 0;
    endfunction

    // Trial division with odd divisors while d*d <= n; count saturates at all ones
    function void note_number(logic [tdpc_pkg::FIELD_BITS-1:0] raw);
        verdict_t    v;
        logic [31:0] n;
        logic [31:0] d;
        logic        prime;
        n = 32'(raw) & ((32'd1 << tdpc_pkg::VALUE_BITS_DEF) - 32'd1);
        if (n <= 32'd1)
            prime = 1'b0;
        else if (n == 32'd2)
            prime = 1'b1;
        else if (!n[0])
            prime = 1'b0;
        else
        begin
            prime = 1'b1;
            for (d = tdpc_pkg::FIRST_DIV; d * d <= n; d += 2)
            begin
                if (n % d == 0)
                begin
                    prime = 1'b0;
                    break;
                end
            end
        end
        if (prime && primes_seen != '1)
            primes_seen++;
        v.is_prime = prime;
        v.tested   = tdpc_pkg::FIELD_BITS'(n);
        v.count    = primes_seen;
        verdicts.push_back(v);
        numbers_noted++;
    endfunction

    function void flag(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_verdict(logic is_p, logic [tdpc_pkg::FIELD_BITS-1:0] tested,
                                logic [tdpc_pkg::COUNT_BITS-1:0] count);
        verdict_t want;
        if (verdicts.size() == 0)
        begin
            flag("result with nothing pending, tested_value", 0, tested);
            return;
        end
        want = verdicts.pop_front();
        verdicts_checked++;
        if (is_p !== want.is_prime)
            flag($sformatf("is_prime for %0d", want.tested), want.is_prime, is_p);
        if (tested !== want.tested)
            flag("tested_value", want.tested, tested);
        if (count !== want.count)
            flag($sformatf("prime_count for %0d", want.tested), want.count, count);
    endfunction

    function int outstanding();
        return verdicts.size();
    endfunction
endclass

module trial_division_prime_counter_tb;

    localparam int HOLD_CYCLES  = 600;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 150;   // final pause before the summary
    localparam int IDLE_LIMIT   = 4000;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_ready;
    logic [tdpc_pkg::FIELD_BITS-1:0]        value;
    logic                                   out_valid;
    logic                                   out_ready;
    logic                                   is_prime;
    logic [tdpc_pkg::FIELD_BITS-1:0]        tested_value;
    logic [tdpc_pkg::COUNT_BITS-1:0]        prime_count;

    prime_scoreboard sb;
    logic            hold_request;
    logic            sender_free;
    logic            receiver_free;
    int              idle_cycles;

    trial_division_prime_counter i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_prime     (is_prime),
        .tested_value (tested_value),
        .prime_count  (prime_count)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // Mix of uniform, small, large odd and products of two odd factors
    function automatic logic [tdpc_pkg::FIELD_BITS-1:0] pick_number();
        int sel;
        int p;
        int q;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return tdpc_pkg::FIELD_BITS'($urandom_range(0, 65535));
        else if (sel < 60)
            return tdpc_pkg::FIELD_BITS'($urandom_range(0, 300));
        else if (sel < 80)
            return tdpc_pkg::FIELD_BITS'($urandom_range(32768, 65535))
                   | tdpc_pkg::FIELD_BITS'(1);
        p = 2 * $urandom_range(1, 127) + 1;
        q = $urandom_range(p, 65535 / p) | 1;
        if (p * q > 65535)
            q -= 2;
        return tdpc_pkg::FIELD_BITS'(p * q);
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken
    task automatic offer_number(input logic [tdpc_pkg::FIELD_BITS-1:0] n, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_number(n);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            offer_number(pick_number(), sender_free ? 0 : pick_gap());
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, free-running stretches and one long hold-off
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!receiver_free)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_verdict(is_prime, tested_value, prime_count);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, sb.outstanding());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [tdpc_pkg::FIELD_BITS-1:0] directed[$];
        sb            = new();
        hold_request  = 1'b0;
        sender_free   = 1'b0;
        receiver_free = 1'b0;
        idle_cycles   = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero, one, two, small odd/even, squares of odd divisors, largest
        // primes, a composite whose first factor is the last divisor tried
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd15,
                     16'd25, 16'd49, 16'd255, 16'd257, 16'd32749, 16'd32767,
                     16'd32768, 16'h5555, 16'hAAAA, 16'd63001, 16'd64507,
                     16'd65025, 16'd65521, 16'd65534, 16'd65535};
        foreach (directed[i])
            offer_number(directed[i], (i % 3 == 0) ? 2 : 0);

        send_random(300);

        // Hold the output off while numbers keep coming, so the block stalls
        hold_request = 1'b1;
        for (int i = 0; i < 10; i++)
            offer_number(pick_number(), 0);
        in_valid <= 1'b0;
        wait_drained();

        // Back-to-back items with the receiver always ready
        sender_free   = 1'b1;
        receiver_free = 1'b1;
        send_random(200);
        sender_free   = 1'b0;
        receiver_free = 1'b0;
        in_valid <= 1'b0;
        wait_drained();

        send_random(370);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tested %0d numbers, %0d results checked, final prime count %0d",
                 sb.numbers_noted, sb.verdicts_checked, sb.primes_seen);
        $display("covered long output hold-off, drain pause and back-to-back bursts");
        if (sb.outstanding() != 0)
            $display("%0d results never arrived", sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> trial_division_prime_counter.f
rtl/core/tdpc_pkg.sv
rtl/core/tdpc_div_unit.sv
rtl/core/trial_division_prime_counter.sv
bench/trial_division_prime_counter_tb.sv
